>>> sv/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master package
// Phase codes, microcode word layout and the control store for the
// transaction sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned WBUF_DEPTH_DEF = 16;
  localparam logic [7:0]  DELAY_RESET    = 8'd5;

  // Item kinds on the command channel
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_BEGIN = 2'd2;

  // Transaction kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_WR_RD   = 2'd2;
  localparam logic [1:0] KIND_INVALID = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_WLO, PH_WHI, PH_ALO, PH_AHI,
    PH_RS1, PH_RS2, PH_RS3, PH_RLO, PH_RHI, PH_KLO, PH_KHI,
    PH_SP1, PH_SP2, PH_SP3
  } phase_t;

  typedef enum logic [1:0] {
    PIN_KEEP, PIN_SET, PIN_CLR
  } pin_op_t;

  // Branch resolved by the datapath at the end of a step
  typedef enum logic [2:0] {
    BR_NEXT,     // go to target
    BR_ADDR,     // load address byte, read bit from kind
    BR_ADDR_RD,  // load address byte with read bit set
    BR_WBIT,     // shift out one bit, loop or go to ACK
    BR_ACK,      // sample ACK, then next byte, read, restart or stop
    BR_RBIT,     // shift in one bit, loop or go to master ACK
    BR_RDEND,    // next read byte or stop
    BR_DONE      // stop complete
  } branch_t;

  typedef struct packed {
    pin_op_t scl;
    pin_op_t sda;
    pin_op_t drv;
    branch_t br;
    phase_t  target;
  } ucode_t;

  function automatic logic apply_pin(input pin_op_t op, input logic cur);
    logic res;
    res = cur;
    case (op)
      PIN_SET: res = 1'b1;
      PIN_CLR: res = 1'b0;
      default: res = cur;
    endcase
    return res;
  endfunction

  // Control store: one word per phase
  function automatic ucode_t ucode_rom(input phase_t ph);
    ucode_t w;
    w = '{PIN_KEEP, PIN_KEEP, PIN_KEEP, BR_NEXT, PH_IDLE};
    unique case (ph)
      PH_IDLE: w = '{PIN_KEEP, PIN_KEEP, PIN_KEEP, BR_NEXT,    PH_IDLE};
      PH_ST1:  w = '{PIN_SET,  PIN_KEEP, PIN_KEEP, BR_NEXT,    PH_ST2};
      PH_ST2:  w = '{PIN_KEEP, PIN_CLR,  PIN_KEEP, BR_NEXT,    PH_ST3};
      PH_ST3:  w = '{PIN_CLR,  PIN_KEEP, PIN_KEEP, BR_ADDR,    PH_WLO};
      PH_WLO:  w = '{PIN_SET,  PIN_KEEP, PIN_KEEP, BR_NEXT,    PH_WHI};
      PH_WHI:  w = '{PIN_CLR,  PIN_KEEP, PIN_KEEP, BR_WBIT,    PH_WLO};
      PH_ALO:  w = '{PIN_SET,  PIN_KEEP, PIN_KEEP, BR_NEXT,    PH_AHI};
      PH_AHI:  w = '{PIN_CLR,  PIN_KEEP, PIN_SET,  BR_ACK,     PH_WLO};
      PH_RS1:  w = '{PIN_SET,  PIN_KEEP, PIN_KEEP, BR_NEXT,    PH_RS2};
      PH_RS2:  w = '{PIN_KEEP, PIN_CLR,  PIN_KEEP, BR_NEXT,    PH_RS3};
      PH_RS3:  w = '{PIN_CLR,  PIN_KEEP, PIN_KEEP, BR_ADDR_RD, PH_WLO};
      PH_RLO:  w = '{PIN_SET,  PIN_KEEP, PIN_KEEP, BR_NEXT,    PH_RHI};
      PH_RHI:  w = '{PIN_CLR,  PIN_KEEP, PIN_KEEP, BR_RBIT,    PH_RLO};
      PH_KLO:  w = '{PIN_SET,  PIN_KEEP, PIN_KEEP, BR_NEXT,    PH_KHI};
      PH_KHI:  w = '{PIN_CLR,  PIN_KEEP, PIN_CLR,  BR_RDEND,   PH_RLO};
      PH_SP1:  w = '{PIN_SET,  PIN_KEEP, PIN_KEEP, BR_NEXT,    PH_SP2};
      PH_SP2:  w = '{PIN_KEEP, PIN_SET,  PIN_KEEP, BR_NEXT,    PH_SP3};
      PH_SP3:  w = '{PIN_KEEP, PIN_KEEP, PIN_KEEP, BR_DONE,    PH_IDLE};
      default: w = '{PIN_KEEP, PIN_KEEP, PIN_KEEP, BR_NEXT,    PH_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> sv/i2cm_wbuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master write buffer
// Single-port-write, single-read byte store with a registered read.
// ----------------------------------------------------------------------------
module i2cm_wbuf #(
  parameter int unsigned DEPTH = i2cm_pkg::WBUF_DEPTH_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read every cycle; the sequencer moves the address well ahead of use
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/i2c_master_transaction_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// I2C master transaction engine
// Microcoded sequencer that runs one I2C write, read or write/restart/read
// transaction, driven by tick commands.
// ----------------------------------------------------------------------------
// Every command taken with start high and busy low gives its result, marked by
// result_strobe, in the next cycle, so busy never rises and a command may be
// issued every cycle. The result is shown for that one cycle only and cannot
// be held off by the receiver. The phase sequencer executes one control-store
// word per elapsed bus delay. Load commands (mode 1) append bytes to the write
// buffer while the bus is idle; a begin command (mode 2) with a valid kind
// latches address, kind and counts and issues a start; tick commands (mode 0)
// count delay_ticks and then execute the word for the current phase. The pin
// levels are reported after every command; received bytes appear with
// rx_valid, and done_res marks the end of the stop condition, with success
// high if no NACK was seen. Write delay_ticks only while the bus is idle.
// ----------------------------------------------------------------------------
module i2c_master_transaction_engine #(
  parameter int unsigned WBUF_DEPTH = i2cm_pkg::WBUF_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // Command channel
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] mode,
  input  wire logic       sda_level,
  input  wire logic [7:0] data_byte,
  input  wire logic [6:0] target_addr,
  input  wire logic [1:0] kind,
  input  wire logic [4:0] write_count,
  input  wire logic [7:0] read_count,
  // Configuration channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  // Result channel
  output logic            result_strobe,
  output logic            scl_out,
  output logic            sda_out,
  output logic            sda_drive_enable,
  output logic            rx_valid,
  output logic [7:0]      rx_byte,
  output logic            done_res,
  output logic            success,
  output logic            busy_res
);

  localparam int unsigned AW    = (WBUF_DEPTH > 1) ? $clog2(WBUF_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(WBUF_DEPTH + 1);

  // Registers
  logic [7:0]       delay_ticks;
  i2cm_pkg::phase_t phase, phase_next;
  logic [7:0]       delay_counter, delay_counter_next;
  logic [3:0]       bit_counter, bit_counter_next;
  logic [7:0]       shift_register, shift_register_next;
  logic [CNT_W-1:0] byte_counter, byte_counter_next;
  logic [CNT_W-1:0] buffer_fill, buffer_fill_next;
  logic [CNT_W-1:0] write_total, write_total_next;
  logic [6:0]       target_address, target_address_next;
  logic [1:0]       transaction_kind, transaction_kind_next;
  logic [7:0]       reads_left, reads_left_next;
  logic             fail_flag, fail_flag_next;
  logic             read_addr_sent, read_addr_sent_next;
  logic             pin_scl, pin_scl_next;
  logic             pin_sda, pin_sda_next;
  logic             pin_drv, pin_drv_next;

  // Step results
  logic             rx_hit;
  logic             done_hit;
  logic             ok_hit;

  logic             accept;
  logic             wbuf_we;
  logic [7:0]       wbuf_rdata;
  logic [8:0]       wc_wide;
  logic [7:0]       delay_limit;
  logic [7:0]       delay_inc;
  logic             fire;
  i2cm_pkg::ucode_t uw;

  // Branch helpers
  logic             do_write;
  logic [7:0]       wr_byte;
  logic             do_stop;
  logic             do_read;
  logic             rds;
  logic [3:0]       bit_inc;
  logic [7:0]       sh_val;
  logic [7:0]       rl_val;

  assign accept    = start && !busy;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Zero delay behaves as one tick
  assign delay_limit = (delay_ticks == 8'd0) ? 8'd1 : delay_ticks;
  assign delay_inc   = delay_counter + 8'd1;
  assign fire        = delay_inc >= delay_limit;
  assign uw          = i2cm_pkg::ucode_rom(phase);
  assign wc_wide     = 9'(write_count);
  assign bit_inc     = bit_counter + 4'd1;

  assign wbuf_we = accept && (mode == i2cm_pkg::MODE_LOAD) && (phase == i2cm_pkg::PH_IDLE)
                   && (buffer_fill < CNT_W'(WBUF_DEPTH));

  i2cm_wbuf #(
    .DEPTH (WBUF_DEPTH),
    .AW    (AW)
  ) u_wbuf (
    .clk   (clk),
    .we    (wbuf_we),
    .waddr (buffer_fill[AW-1:0]),
    .wdata (data_byte),
    .raddr (byte_counter[AW-1:0]),
    .rdata (wbuf_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks <= i2cm_pkg::DELAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      delay_ticks <= cfg_data;
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= i2cm_pkg::PH_IDLE;
      delay_counter    <= '0;
      bit_counter      <= '0;
      shift_register   <= '0;
      byte_counter     <= '0;
      buffer_fill      <= '0;
      write_total      <= '0;
      target_address   <= '0;
      transaction_kind <= '0;
      reads_left       <= '0;
      fail_flag        <= 1'b0;
      read_addr_sent   <= 1'b0;
      pin_scl          <= 1'b1;
      pin_sda          <= 1'b1;
      pin_drv          <= 1'b1;
    end else if (accept) begin
      phase            <= phase_next;
      delay_counter    <= delay_counter_next;
      bit_counter      <= bit_counter_next;
      shift_register   <= shift_register_next;
      byte_counter     <= byte_counter_next;
      buffer_fill      <= buffer_fill_next;
      write_total      <= write_total_next;
      target_address   <= target_address_next;
      transaction_kind <= transaction_kind_next;
      reads_left       <= reads_left_next;
      fail_flag        <= fail_flag_next;
      read_addr_sent   <= read_addr_sent_next;
      pin_scl          <= pin_scl_next;
      pin_sda          <= pin_sda_next;
      pin_drv          <= pin_drv_next;
    end
  end

  // Next state: hold, apply load/begin, else run the control word at delay end
  always_comb begin
    phase_next            = phase;
    delay_counter_next    = delay_counter;
    bit_counter_next      = bit_counter;
    shift_register_next   = shift_register;
    byte_counter_next     = byte_counter;
    buffer_fill_next      = buffer_fill;
    write_total_next      = write_total;
    target_address_next   = target_address;
    transaction_kind_next = transaction_kind;
    reads_left_next       = reads_left;
    fail_flag_next        = fail_flag;
    read_addr_sent_next   = read_addr_sent;
    pin_scl_next          = pin_scl;
    pin_sda_next          = pin_sda;
    pin_drv_next          = pin_drv;
    rx_hit                = 1'b0;
    done_hit              = 1'b0;
    ok_hit                = 1'b0;
    do_write              = 1'b0;
    wr_byte               = 8'd0;
    do_stop               = 1'b0;
    do_read               = 1'b0;
    rds                   = 1'b0;
    sh_val                = 8'd0;
    rl_val                = reads_left;

    if (mode == i2cm_pkg::MODE_LOAD) begin
      if (wbuf_we) begin
        buffer_fill_next = buffer_fill + CNT_W'(1);
      end
    end else if (mode == i2cm_pkg::MODE_BEGIN) begin
      if (phase == i2cm_pkg::PH_IDLE && kind != i2cm_pkg::KIND_INVALID) begin
        target_address_next   = target_addr;
        transaction_kind_next = kind;
        // Clamp the write count to the buffer depth
        write_total_next      = (wc_wide > 9'(WBUF_DEPTH)) ? CNT_W'(WBUF_DEPTH)
                                                           : CNT_W'(wc_wide);
        reads_left_next       = read_count;
        byte_counter_next     = '0;
        buffer_fill_next      = '0;
        fail_flag_next        = 1'b0;
        read_addr_sent_next   = 1'b0;
        delay_counter_next    = '0;
        pin_drv_next          = 1'b1;
        pin_sda_next          = 1'b1;
        phase_next            = i2cm_pkg::PH_ST1;
      end
    end else if (mode == i2cm_pkg::MODE_TICK && phase != i2cm_pkg::PH_IDLE) begin
      if (!fire) begin
        delay_counter_next = delay_inc;
      end else begin
        delay_counter_next = '0;
        pin_scl_next = i2cm_pkg::apply_pin(uw.scl, pin_scl);
        pin_sda_next = i2cm_pkg::apply_pin(uw.sda, pin_sda);
        pin_drv_next = i2cm_pkg::apply_pin(uw.drv, pin_drv);
        phase_next   = uw.target;

        unique case (uw.br)
          i2cm_pkg::BR_NEXT: begin
            phase_next = uw.target;
          end
          i2cm_pkg::BR_ADDR, i2cm_pkg::BR_ADDR_RD: begin
            rds = (uw.br == i2cm_pkg::BR_ADDR_RD)
                  || (transaction_kind == i2cm_pkg::KIND_READ);
            read_addr_sent_next = rds;
            do_write = 1'b1;
            wr_byte  = {target_address, rds};
          end
          i2cm_pkg::BR_WBIT: begin
            sh_val              = {shift_register[6:0], 1'b0};
            shift_register_next = sh_val;
            bit_counter_next    = bit_inc;
            if (!bit_inc[3]) begin
              pin_sda_next = sh_val[7];
              phase_next   = i2cm_pkg::PH_WLO;
            end else begin
              pin_drv_next = 1'b0;
              phase_next   = i2cm_pkg::PH_ALO;
            end
          end
          i2cm_pkg::BR_ACK: begin
            if (sda_level) begin
              fail_flag_next = 1'b1;
              do_stop        = 1'b1;
            end else if (read_addr_sent) begin
              do_stop = (reads_left == 8'd0);
              do_read = (reads_left != 8'd0);
            end else if (byte_counter < write_total) begin
              byte_counter_next = byte_counter + CNT_W'(1);
              do_write          = 1'b1;
              wr_byte           = wbuf_rdata;
            end else if (transaction_kind == i2cm_pkg::KIND_WR_RD) begin
              pin_sda_next = 1'b1;
              phase_next   = i2cm_pkg::PH_RS1;
            end else begin
              do_stop = 1'b1;
            end
          end
          i2cm_pkg::BR_RBIT: begin
            sh_val              = {shift_register[6:0], sda_level};
            shift_register_next = sh_val;
            bit_counter_next    = bit_inc;
            if (!bit_inc[3]) begin
              phase_next = i2cm_pkg::PH_RLO;
            end else begin
              rx_hit = 1'b1;
              if (reads_left != 8'd0) begin
                rl_val = reads_left - 8'd1;
              end
              reads_left_next = rl_val;
              pin_drv_next    = 1'b1;
              // NACK the last byte
              pin_sda_next    = (rl_val == 8'd0);
              phase_next      = i2cm_pkg::PH_KLO;
            end
          end
          i2cm_pkg::BR_RDEND: begin
            do_stop = (reads_left == 8'd0);
            do_read = (reads_left != 8'd0);
          end
          i2cm_pkg::BR_DONE: begin
            phase_next = i2cm_pkg::PH_IDLE;
            done_hit   = 1'b1;
            ok_hit     = !fail_flag;
          end
          default: begin
            phase_next = i2cm_pkg::PH_IDLE;
          end
        endcase

        if (do_write) begin
          shift_register_next = wr_byte;
          bit_counter_next    = '0;
          pin_drv_next        = 1'b1;
          pin_sda_next        = wr_byte[7];
          phase_next          = i2cm_pkg::PH_WLO;
        end
        if (do_stop) begin
          pin_drv_next = 1'b1;
          pin_sda_next = 1'b0;
          phase_next   = i2cm_pkg::PH_SP1;
        end
        if (do_read) begin
          pin_drv_next        = 1'b0;
          bit_counter_next    = '0;
          shift_register_next = '0;
          phase_next          = i2cm_pkg::PH_RLO;
        end
      end
    end
  end

  // Result register: strobe in the cycle after each accepted command
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
      rx_valid      <= 1'b0;
      done_res      <= 1'b0;
      success       <= 1'b0;
    end else begin
      result_strobe <= accept;
      rx_valid      <= accept && rx_hit;
      done_res      <= accept && done_hit;
      success       <= accept && ok_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rx_byte <= rx_hit ? shift_register_next : 8'd0;
    end
  end

  assign scl_out          = pin_scl;
  assign sda_out          = pin_sda;
  assign sda_drive_enable = pin_drv;
  assign busy_res         = (phase != i2cm_pkg::PH_IDLE);

  // Checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done_res |-> (result_strobe && !busy_res))
    else $error("done reported while a transaction is still running");

  a_rx_in_txn: assert property (@(posedge clk) disable iff (rst)
    rx_valid |-> (result_strobe && busy_res && sda_drive_enable))
    else $error("received byte outside a read phase");

  a_success_done: assert property (@(posedge clk) disable iff (rst)
    success |-> done_res)
    else $error("success without done");

  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_counter <= 4'd8)
    else $error("bit counter out of range");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    buffer_fill <= CNT_W'(WBUF_DEPTH))
    else $error("write buffer overfilled");

  a_read_released: assert property (@(posedge clk) disable iff (rst)
    (phase == i2cm_pkg::PH_RHI) |-> !pin_drv)
    else $error("SDA driven while sampling a read bit");

endmodule
`default_nettype wire
